// ===== rtl/sue_pkg.sv =====
package sue_pkg;

   // Default oversample ratio as a power of two (four ticks per bit).
   localparam int OVS_LOG2_DEFAULT = 2;

   // Entries in each of the two internal queues.
   localparam int QUEUE_DEPTH = 2;

   // Reset value of the prefix register ('!').
   localparam logic [7:0] PREFIX_RESET = 8'h21;

   // LED command bytes.
   localparam logic [7:0] CMD_ON     = 8'h4E;  // 'N'
   localparam logic [7:0] CMD_TOGGLE = 8'h54;  // 'T'

   // Bit slots of an 8N1 frame, counted in whole bit periods.
   localparam logic [3:0] SLOT_START      = 4'd1;
   localparam logic [3:0] SLOT_FIRST_DATA = 4'd2;
   localparam logic [3:0] SLOT_LAST_DATA  = 4'd9;
   localparam logic [3:0] SLOT_STOP       = 4'd10;
   localparam logic [3:0] SLOT_END        = 4'd11;

   // What the receiver hands to the back end for one tick.
   typedef struct packed {
      logic       rx_done;
      logic [7:0] rx_data;
   } rx_rec_type;

   // One result of a tick.
   typedef struct packed {
      logic       tx_level;
      logic       led_on;
      logic       host_valid;
      logic [7:0] host_byte;
   } result_type;

endpackage

// ===== rtl/sue_queue.sv =====
module sue_queue #(
   parameter int Width = 8,
   parameter int Depth = sue_pkg::QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [Width-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [Width-1:0] pop_data,
   output logic             empty
);

   localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CountW = $clog2(Depth + 1);
   localparam logic [AddrW-1:0] LastAddr = AddrW'(Depth - 1);
   localparam logic [CountW-1:0] FullCount = CountW'(Depth);

   logic [Width-1:0]  store_ff [Depth];
   logic [AddrW-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [AddrW-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CountW-1:0] count_ff, count_in;
   logic              do_push, do_pop;

   assign full     = (count_ff == FullCount);
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = store_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LastAddr) ? '0 : wr_ptr_ff + AddrW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LastAddr) ? '0 : rd_ptr_ff + AddrW'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CountW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CountW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         store_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== rtl/sue_rx_front.sv =====
module sue_rx_front #(
   parameter int OvsLog2 = sue_pkg::OVS_LOG2_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                tick,
   input  logic                rx_level,
   output sue_pkg::rx_rec_type rec
);

   localparam int CntW = OvsLog2 + 4;
   localparam logic [CntW-1:0] OvsCount = CntW'(1) << OvsLog2;
   localparam logic [OvsLog2-1:0] HalfPhase = OvsLog2'(1) << (OvsLog2 - 1);

   logic [CntW-1:0]    cnt_ff, cnt_in;
   logic [7:0]         shift_ff, shift_in;
   logic [CntW-1:0]    next_cnt;
   logic [3:0]         slot;
   logic [OvsLog2-1:0] phase;

   assign next_cnt = cnt_ff + CntW'(1);
   assign slot     = next_cnt[CntW-1:OvsLog2];
   assign phase    = next_cnt[OvsLog2-1:0];

   always_comb begin
      cnt_in   = cnt_ff;
      shift_in = shift_ff;
      rec      = '0;
      if (tick) begin
         if (cnt_ff == '0) begin
            // Idle: a low level is the start bit.
            if (!rx_level) begin
               cnt_in = OvsCount;
            end
         end else begin
            cnt_in = next_cnt;
            if (phase == HalfPhase) begin
               if (slot >= sue_pkg::SLOT_FIRST_DATA && slot <= sue_pkg::SLOT_LAST_DATA) begin
                  shift_in = {rx_level, shift_ff[7:1]};
                  if (slot == sue_pkg::SLOT_LAST_DATA) begin
                     rec.rx_done = 1'b1;
                     rec.rx_data = shift_in;
                  end
               end
            end else if (slot == sue_pkg::SLOT_STOP) begin
               cnt_in = '0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff   <= '0;
         shift_ff <= '0;
      end else begin
         cnt_ff   <= cnt_in;
         shift_ff <= shift_in;
      end
   end

endmodule

// ===== rtl/sue_tx_back.sv =====
module sue_tx_back #(
   parameter int OvsLog2 = sue_pkg::OVS_LOG2_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                step,
   input  sue_pkg::rx_rec_type rec,
   input  logic                prefix_wr,
   input  logic [7:0]          prefix_data,
   output sue_pkg::result_type result
);

   localparam int CntW = OvsLog2 + 4;
   localparam logic [CntW-1:0] OvsCount = CntW'(1) << OvsLog2;

   logic [CntW-1:0]    cnt_ff, cnt_in;
   logic [7:0]         tx_shift_ff, tx_shift_in;
   logic               tx_go_ff, tx_go_in;
   logic [7:0]         pending_ff, pending_in;
   logic               pending_valid_ff, pending_valid_in;
   logic               tx_line_ff, tx_line_in;
   logic               led_ff, led_in;
   logic               armed_ff, armed_in;
   logic [7:0]         prefix_ff;
   logic [CntW-1:0]    adv_cnt;
   logic [3:0]         slot;
   logic [OvsLog2-1:0] phase;
   logic [2:0]         data_idx;

   assign adv_cnt  = (cnt_ff == '0) ? OvsCount : cnt_ff + CntW'(1);
   assign slot     = adv_cnt[CntW-1:OvsLog2];
   assign phase    = adv_cnt[OvsLog2-1:0];
   assign data_idx = 3'(slot - sue_pkg::SLOT_FIRST_DATA);

   always_comb begin
      cnt_in           = cnt_ff;
      tx_shift_in      = tx_shift_ff;
      tx_go_in         = tx_go_ff;
      pending_in       = pending_ff;
      pending_valid_in = pending_valid_ff;
      tx_line_in       = tx_line_ff;
      led_in           = led_ff;
      armed_in         = armed_ff;

      // Transmitter advances while a frame is loaded or running.
      if (tx_go_ff || cnt_ff != '0) begin
         cnt_in   = adv_cnt;
         tx_go_in = 1'b0;
         if (phase == '0) begin
            priority if (slot == sue_pkg::SLOT_START) begin
               tx_line_in = 1'b0;
            end else if (slot >= sue_pkg::SLOT_FIRST_DATA &&
                         slot <= sue_pkg::SLOT_LAST_DATA) begin
               tx_line_in = tx_shift_ff[data_idx];
            end else if (slot == sue_pkg::SLOT_STOP) begin
               tx_line_in = 1'b1;
            end else if (slot == sue_pkg::SLOT_END) begin
               tx_line_in = 1'b1;
               cnt_in     = '0;
            end else begin
               tx_line_in = tx_line_ff;
            end
         end
      end

      // Hand the pending byte to an idle transmitter.
      if (pending_valid_ff && cnt_in == '0) begin
         pending_valid_in = 1'b0;
         tx_go_in         = 1'b1;
         tx_shift_in      = pending_ff;
      end

      if (rec.rx_done) begin
         if (armed_ff) begin
            armed_in = 1'b0;
            priority if (rec.rx_data == sue_pkg::CMD_ON) begin
               led_in = 1'b1;
            end else if (rec.rx_data == sue_pkg::CMD_TOGGLE) begin
               led_in = !led_ff;
            end else begin
               led_in = 1'b0;
            end
         end else begin
            if (rec.rx_data == prefix_ff) begin
               armed_in = 1'b1;
            end
            pending_valid_in = 1'b1;
            pending_in       = rec.rx_data;
         end
      end

      result.tx_level   = tx_line_in;
      result.led_on     = led_in;
      result.host_valid = rec.rx_done;
      result.host_byte  = rec.rx_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff           <= '0;
         tx_shift_ff      <= '0;
         tx_go_ff         <= 1'b0;
         pending_ff       <= '0;
         pending_valid_ff <= 1'b0;
         tx_line_ff       <= 1'b1;
         led_ff           <= 1'b0;
         armed_ff         <= 1'b0;
      end else if (step) begin
         cnt_ff           <= cnt_in;
         tx_shift_ff      <= tx_shift_in;
         tx_go_ff         <= tx_go_in;
         pending_ff       <= pending_in;
         pending_valid_ff <= pending_valid_in;
         tx_line_ff       <= tx_line_in;
         led_ff           <= led_in;
         armed_ff         <= armed_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prefix_ff <= sue_pkg::PREFIX_RESET;
      end else if (prefix_wr) begin
         prefix_ff <= prefix_data;
      end
   end

endmodule

// ===== rtl/soft_uart_echo_led_command_top.sv =====
// Channel   Direction  Transfer condition          Payload
// req       in         req_push && !req_full       req_rx_level
// rsp       out        rsp_pop && !rsp_empty       rsp_tx_level, rsp_led_on,
//                                                   rsp_host_valid, rsp_host_byte
// csr       in         csr_valid && csr_ready      csr_prefix_char
//
// Every transfer on req is one oversample tick and yields exactly one result on rsp.
// One tick per clock cycle is sustained while rsp is popped; a result reaches rsp after
// its record leaves the receiver queue and the back end writes it into the result queue.
// Reset is synchronous and active high; it idles both UART halves and restores
// the prefix to '!'. A stalled rsp side fills the result queue, then the receiver
// queue, and only then raises req_full.
module soft_uart_echo_led_command_top #(
   parameter int OvsLog2 = sue_pkg::OVS_LOG2_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_push,
   input  logic       req_rx_level,
   output logic       req_full,
   output logic       rsp_empty,
   input  logic       rsp_pop,
   output logic       rsp_tx_level,
   output logic       rsp_led_on,
   output logic       rsp_host_valid,
   output logic [7:0] rsp_host_byte,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [7:0] csr_prefix_char
);

   localparam int RecW = $bits(sue_pkg::rx_rec_type);
   localparam int ResW = $bits(sue_pkg::result_type);

   sue_pkg::rx_rec_type front_rec;
   sue_pkg::rx_rec_type back_rec;
   sue_pkg::result_type back_result;
   sue_pkg::result_type rsp_result;
   logic                accept;
   logic                mid_empty;
   logic                res_full;
   logic                back_step;
   logic [RecW-1:0]     mid_data;
   logic [ResW-1:0]     res_data;

   // The receiver updates on every accepted tick; its record for each tick, with any decoded
   // byte event, goes into a short queue so that the back end may stall on its own.
   assign accept = req_push && !req_full;

   sue_rx_front #(
      .OvsLog2 (OvsLog2)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .tick     (accept),
      .rx_level (req_rx_level),
      .rec      (front_rec)
   );

   sue_queue #(
      .Width (RecW)
   ) u_mid_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (req_push),
      .push_data (front_rec),
      .full      (req_full),
      .pop       (back_step),
      .pop_data  (mid_data),
      .empty     (mid_empty)
   );

   assign back_rec  = sue_pkg::rx_rec_type'(mid_data);

   // The back end takes one tick whenever a record is queued and there is room for its result.
   assign back_step = !mid_empty && !res_full;

   sue_tx_back #(
      .OvsLog2 (OvsLog2)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .step        (back_step),
      .rec         (back_rec),
      .prefix_wr   (csr_valid),
      .prefix_data (csr_prefix_char),
      .result      (back_result)
   );

   sue_queue #(
      .Width (ResW)
   ) u_res_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (back_step),
      .push_data (back_result),
      .full      (res_full),
      .pop       (rsp_pop),
      .pop_data  (res_data),
      .empty     (rsp_empty)
   );

   assign rsp_result     = sue_pkg::result_type'(res_data);
   assign rsp_tx_level   = rsp_result.tx_level;
   assign rsp_led_on     = rsp_result.led_on;
   assign rsp_host_valid = rsp_result.host_valid;
   assign rsp_host_byte  = rsp_result.host_byte;

   // The prefix register takes a write in any cycle.
   assign csr_ready = 1'b1;

endmodule
